### design/scv_pkg.sv
// Shared types and constants for the state-of-charge curve check.
package scv_pkg;

  localparam int ROM_DEPTH      = 16;
  localparam int ADDR_W         = $clog2(ROM_DEPTH);
  localparam int NUM_POINTS_DEF = 8;

  localparam int VOLT_W   = 13;
  localparam int CHARGE_W = 17;
  localparam int PCT_W    = 7;
  localparam int TOL_W    = 8;
  localparam int VERR_W   = 8;

  // The slope divider takes the charge difference of a segment as its dividend.
  localparam int DIV_W     = CHARGE_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Division by 1000 is a multiply by the rounded-up reciprocal 2^35 / 1000 followed by a
  // shift. It is exact for every dividend below 2^25, which covers slope times voltage error.
  localparam int TPROD_W     = CHARGE_W + VERR_W;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 26'd34359739;
  localparam int SCALE_W     = TPROD_W + RECIP_W;
  localparam int QUOT_W      = SCALE_W - RECIP_SHIFT;

  localparam logic [TOL_W-1:0]    TOL_MAX      = 8'd255;
  localparam logic [VERR_W-1:0]   VERR_RESET   = 8'd53;
  localparam logic [PCT_W-1:0]    MIN_TOL_RESET = 7'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_ERROR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOL    = 1'b1;

  // Curve points ordered by falling voltage; unused points read as zero.
  localparam logic [VOLT_W-1:0] CURVE_VOLT [ROM_DEPTH] = '{
    13'd4100, 13'd3893, 13'd3783, 13'd3721, 13'd3686, 13'd3575, 13'd3487, 13'd3300,
    13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
  };
  localparam logic [CHARGE_W-1:0] CURVE_CHARGE [ROM_DEPTH] = '{
    17'd100000, 17'd75000, 17'd57000, 17'd36000,
    17'd20000, 17'd4000, 17'd2000, 17'd0,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic [PCT_W-1:0]  capacity_pct;
  } in_word_t;

  typedef struct packed {
    logic              is_valid;
    logic [PCT_W-1:0]  expected_pct;
    logic [TOL_W-1:0]  tolerance_pct;
  } out_word_t;

endpackage

### design/soc_curve_interp_validate.sv
// Top level of the state-of-charge curve check: segment search, slope, estimate, tolerance.
// Each search step costs one curve ROM read; the search ends at a segment in 1 .. NUM_POINTS-1.
// A new word is taken only in idle, after the search, the 17-step slope divider and the rest
// of the sequence have run and the result has entered the output register.
// Reset (rst, synchronous, active high) clears control state, loads 53 mV and 5 percent.
module soc_curve_interp_validate #(
  parameter int NUM_POINTS = scv_pkg::NUM_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [scv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scv_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scv_pkg::out_word_t            out_data
);
  import scv_pkg::*;

  // Index of the last curve point in use.
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_POINTS - 1);
  localparam logic [DIV_CNT_W-1:0] SHORT_STEPS = DIV_CNT_W'(CHARGE_W);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RD        = 4'd1;
  localparam logic [3:0] S_CMP       = 4'd2;
  localparam logic [3:0] S_RD_HI     = 4'd3;
  localparam logic [3:0] S_HI        = 4'd4;
  localparam logic [3:0] S_DIV_SLOPE = 4'd5;
  localparam logic [3:0] S_MUL       = 4'd6;
  localparam logic [3:0] S_CLAMP     = 4'd7;
  localparam logic [3:0] S_SCALE_EXP = 4'd8;
  localparam logic [3:0] S_SCALE_TOL = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0] state;

  // Configuration registers.
  logic [VERR_W-1:0] volt_err;
  logic [PCT_W-1:0]  min_tol;

  // Latched input word.
  logic [VOLT_W-1:0] x;
  logic [PCT_W-1:0]  cap;

  // Curve ROM address and registered read data.
  logic [ADDR_W-1:0]   addr;
  logic [VOLT_W-1:0]   volt_q;
  logic [CHARGE_W-1:0] charge_q;

  // Segment end points and intermediate results.
  logic [VOLT_W-1:0]   vlo;
  logic [CHARGE_W-1:0] clo;
  logic [CHARGE_W-1:0] chi;
  logic                dx_zero;
  logic [CHARGE_W-1:0] slope;
  logic signed [31:0]  y_prod;
  logic [TPROD_W-1:0]  tprod;
  logic [CHARGE_W-1:0] est;
  logic [PCT_W-1:0]    expected;
  logic [QUOT_W-1:0]   scale_q;

  // Restoring divider for the slope.
  logic [VOLT_W-1:0]    div_rem;
  logic [DIV_W-1:0]     div_dq;
  logic [VOLT_W-1:0]    div_dvsr;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [VOLT_W:0]      rem_sh;
  logic [VOLT_W:0]      rem_sub;
  logic                 rem_ge;
  logic [VOLT_W-1:0]    rem_next;
  logic [DIV_W-1:0]     dq_next;
  logic                 div_last;

  // Combinational helpers.
  logic [VOLT_W-1:0]   dx;
  logic [CHARGE_W-1:0] dy;
  logic signed [32:0]  y_sum;
  logic signed [32:0]  chi_s;
  logic signed [32:0]  clo_s;
  logic signed [32:0]  y_clamp;
  logic [TPROD_W-1:0]  scale_in;
  logic [SCALE_W-1:0]  scale_prod;
  logic [TOL_W-1:0]    tol_sel;
  logic [TOL_W+1:0]    win_hi;
  logic [TOL_W+1:0]    cap_plus;
  logic                ok;
  logic                out_free;

  // One divider step per cycle: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    rem_sh   = {div_rem, div_dq[DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, div_dvsr};
    rem_ge   = rem_sh >= {1'b0, div_dvsr};
    rem_next = rem_ge ? rem_sub[VOLT_W-1:0] : rem_sh[VOLT_W-1:0];
    dq_next  = {div_dq[DIV_W-2:0], rem_ge};
    div_last = div_cnt == DIV_CNT_W'(1);
  end

  // The curve falls, so both differences of a segment are never negative.
  always_comb begin
    dx = volt_q - vlo;
    dy = charge_q - clo;
  end

  // Line estimate clo + (x - vlo) * slope, clamped to the segment's end charges.
  always_comb begin
    y_sum = 33'(y_prod) + $signed({16'd0, clo});
    chi_s = $signed({16'd0, chi});
    clo_s = $signed({16'd0, clo});
    if (chi > clo) begin
      if (y_sum > chi_s) y_clamp = chi_s;
      else if (y_sum < clo_s) y_clamp = clo_s;
      else y_clamp = y_sum;
    end else begin
      if (y_sum < chi_s) y_clamp = chi_s;
      else if (y_sum > clo_s) y_clamp = clo_s;
      else y_clamp = y_sum;
    end
  end

  // Both divisions by 1000 share one reciprocal multiply: the clamped estimate first,
  // then slope times voltage error. The quotient is the product's upper bits.
  always_comb begin
    scale_in   = (state == S_SCALE_EXP) ? TPROD_W'(est) : tprod;
    scale_prod = SCALE_W'(scale_in) * SCALE_W'(RECIP_1000);
  end

  // Tolerance is raised to the configured floor and saturates at the field's limit.
  // The window test expected - tol < cap < expected + tol is written without subtraction.
  always_comb begin
    if (scale_q < {{(QUOT_W-PCT_W){1'b0}}, min_tol}) tol_sel = {1'b0, min_tol};
    else if (scale_q > {{(QUOT_W-TOL_W){1'b0}}, TOL_MAX}) tol_sel = TOL_MAX;
    else tol_sel = scale_q[TOL_W-1:0];
    win_hi   = {3'd0, expected} + {2'd0, tol_sel};
    cap_plus = {3'd0, cap} + {2'd0, tol_sel};
    ok       = ({3'd0, cap} < win_hi) && (cap_plus > {3'd0, expected});
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_err <= VERR_RESET;
      min_tol  <= MIN_TOL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_VOLT_ERROR: volt_err <= cfg_data;
        REG_MIN_TOL:    min_tol  <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Curve ROMs with a registered read port.
  always_ff @(posedge clk) begin
    volt_q   <= CURVE_VOLT[addr];
    charge_q <= CURVE_CHARGE[addr];
  end

  // Sequencer: search, slope division, multiply, clamp, two scale steps, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= in_data.voltage_mv;
            cap   <= in_data.capacity_pct;
            addr  <= ADDR_W'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          // Advance while the voltage lies below this point, stopping at the last point.
          if (addr < LAST_IDX && x < volt_q) begin
            addr  <= addr + ADDR_W'(1);
            state <= S_RD;
          end else begin
            vlo   <= volt_q;
            clo   <= charge_q;
            addr  <= addr - ADDR_W'(1);
            state <= S_RD_HI;
          end
        end
        S_RD_HI: begin
          state <= S_HI;
        end
        S_HI: begin
          chi      <= charge_q;
          dx_zero  <= dx == '0;
          div_dq   <= dy;
          div_dvsr <= dx;
          div_rem  <= '0;
          div_cnt  <= SHORT_STEPS;
          state    <= S_DIV_SLOPE;
        end
        S_DIV_SLOPE: begin
          div_rem <= rem_next;
          div_dq  <= dq_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_last) begin
            // A flat segment has no defined slope and is taken as level.
            slope <= dx_zero ? '0 : dq_next[CHARGE_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          y_prod <= 32'($signed({1'b0, x}) - $signed({1'b0, vlo}))
                    * 32'($signed({1'b0, slope}));
          tprod  <= TPROD_W'(slope) * TPROD_W'(volt_err);
          state  <= S_CLAMP;
        end
        S_CLAMP: begin
          est   <= y_clamp[CHARGE_W-1:0];
          state <= S_SCALE_EXP;
        end
        S_SCALE_EXP: begin
          scale_q <= scale_prod[SCALE_W-1:RECIP_SHIFT];
          state   <= S_SCALE_TOL;
        end
        S_SCALE_TOL: begin
          // The estimate never exceeds 100 percent, so its quotient fits the field.
          expected <= scale_q[PCT_W-1:0];
          scale_q  <= scale_prod[SCALE_W-1:RECIP_SHIFT];
          state    <= S_OUT;
        end
        S_OUT: begin
          // The output register holds the previous word until it has been taken.
          if (out_free) begin
            out_data.is_valid      <= ok;
            out_data.expected_pct  <= expected;
            out_data.tolerance_pct <= tol_sel;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### dv/tb.sv
// Self-checking testbench for the voltage-curve state-of-charge check.
`timescale 1ns / 1ps

module tb;
  import scv_pkg::*;

  // Eight curve points, ordered by falling voltage, and charge in thousandths of a percent.
  localparam int NPTS = 8;
  localparam int MILLI = 1000;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int PHASES = 9;
  localparam int READINGS_PER_PHASE = 128;
  localparam int SHOWN_MISMATCHES = 10;

  int curve_mv [NPTS] = '{4100, 3893, 3783, 3721, 3686, 3575, 3487, 3300};
  int curve_mpct [NPTS] = '{100000, 75000, 57000, 36000, 20000, 4000, 2000, 0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VOLT_ERROR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  // Local copy of the two registers, mirrored at every write.
  logic [VERR_W-1:0] verr_cfg = VERR_RESET;
  logic [PCT_W-1:0] mintol_cfg = MIN_TOL_RESET;

  // Readings waiting to be driven and results predicted for accepted readings.
  in_word_t pending_words [$];
  out_word_t predicted_results [$];

  int cycle_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int inside_count = 0;
  int outside_count = 0;
  int mismatch_count = 0;
  int unexpected_count = 0;
  int settings_seen = 1;

  // Sender burst state and receiver stall state.
  int burst_left = 0;
  int gap_left = 0;
  logic next_valid;
  logic send_now;
  int rx_tick = 0;
  int rx_hold = 0;
  logic rx_rdy;
  out_word_t want;

  soc_curve_interp_validate dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Predicted outcome of one gauge reading under the current register values.
  // The segment search walks down the curve from the second point while the voltage is
  // below that point, so voltages above the curve land on the first segment and voltages
  // below it on the last; the clamp then pins the estimate to the segment's end charge.
  function automatic out_word_t estimate_soc(in_word_t w);
    longint x, cap, vhi, vlo, chi, clo, dx, dy, slope, icpt, est, tol, pct;
    int seg;
    out_word_t r;
    x = longint'(w.voltage_mv);
    cap = longint'(w.capacity_pct);
    seg = 1;
    while (seg < NPTS - 1 && x < curve_mv[seg]) seg++;
    vhi = curve_mv[seg - 1];
    vlo = curve_mv[seg];
    chi = curve_mpct[seg - 1];
    clo = curve_mpct[seg];
    dx = vhi - vlo;
    dy = chi - clo;
    // A flat segment (two points at one voltage) has no slope.
    slope = (dx != 0) ? dy / dx : 0;
    icpt = clo - vlo * slope;
    est = x * slope + icpt;
    if (chi > clo) begin
      if (est > chi) est = chi;
      else if (est < clo) est = clo;
    end else begin
      if (est < chi) est = chi;
      else if (est > clo) est = clo;
    end
    // SystemVerilog signed division truncates toward zero, as the tolerance requires.
    tol = slope * longint'(verr_cfg) / MILLI;
    if (tol < 0) tol = -tol;
    if (tol < longint'(mintol_cfg)) tol = longint'(mintol_cfg);
    if (tol > 255) tol = 255;
    pct = est / MILLI;
    // Signed window: the lower bound may go negative near an empty cell.
    r.is_valid = (cap < pct + tol) && (cap > pct - tol);
    r.expected_pct = pct[PCT_W-1:0];
    r.tolerance_pct = tol[TOL_W-1:0];
    return r;
  endfunction

  // Queue a reading whose capacity sits relative to the acceptance window:
  // side picks the upper (+1), lower (-1) or center (0) of the window, delta shifts it.
  task automatic queue_near(input int volt, input int side, input int delta);
    in_word_t w;
    out_word_t p;
    int c;
    w.voltage_mv = volt[VOLT_W-1:0];
    w.capacity_pct = '0;
    p = estimate_soc(w);
    c = int'(p.expected_pct) + side * int'(p.tolerance_pct) + delta;
    if (c < 0) c = 0;
    if (c > 127) c = 127;
    w.capacity_pct = c[PCT_W-1:0];
    pending_words.push_back(w);
  endtask

  task automatic queue_plain(input int volt, input int cap);
    in_word_t w;
    w.voltage_mv = volt[VOLT_W-1:0];
    w.capacity_pct = cap[PCT_W-1:0];
    pending_words.push_back(w);
  endtask

  // Random reading: most voltages fall on the curve's span or right around its points,
  // the rest cover the whole field. Half the capacities hug a window edge so that the
  // valid flag flips often; the others are spread over the field.
  task automatic queue_random_reading();
    int r;
    int volt;
    r = $urandom_range(0, 99);
    if (r < 65) volt = $urandom_range(3250, 4150);
    else if (r < 85) volt = curve_mv[$urandom_range(0, NPTS - 1)] + int'($urandom_range(0, 6)) - 3;
    else volt = $urandom_range(0, 8191);
    r = $urandom_range(0, 99);
    if (r < 50) queue_near(volt, $urandom_range(0, 1) ? 1 : -1, int'($urandom_range(0, 4)) - 2);
    else if (r < 80) queue_plain(volt, $urandom_range(0, 100));
    else queue_plain(volt, $urandom_range(0, 127));
  endtask

  // Registers change only with the block idle, so the mirror is updated right away.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_VOLT_ERROR) verr_cfg = val;
    else mintol_cfg = val[PCT_W-1:0];
  endtask

  // Every reading produces exactly one result, so an empty prediction store with
  // nothing left to send means the block is idle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 70) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 40);
    return $urandom_range(41, 100);
  endfunction

  // Driver: a new word is presented only when the line is free or the current word is
  // taken, so valid and the payload hold steady until the handshake. The prediction is
  // made at the accepting edge, from the word actually accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      send_now = in_valid && in_ready;
      if (send_now) begin
        predicted_results.push_back(estimate_soc(in_data));
        words_sent++;
      end
      if (!in_valid || send_now) begin
        next_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          in_data <= pending_words.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left = pick_gap();
          end else begin
            burst_left--;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor and receiver: each taken result is checked against the oldest prediction.
  // The receiver cycles through four moods in turn: always ready,
  // coin-flip ready, mostly stalled, and ready with occasional long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          unexpected_count++;
          if (unexpected_count + mismatch_count <= SHOWN_MISMATCHES)
            $display("[%0t] result with no reading outstanding: valid=%0b pct=%0d tol=%0d",
                     $realtime, out_data.is_valid, out_data.expected_pct,
                     out_data.tolerance_pct);
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          if (want.is_valid) inside_count++;
          else outside_count++;
          if (out_data.is_valid !== want.is_valid ||
              out_data.expected_pct !== want.expected_pct ||
              out_data.tolerance_pct !== want.tolerance_pct) begin
            mismatch_count++;
            if (unexpected_count + mismatch_count <= SHOWN_MISMATCHES)
              $display("[%0t] word %0d: expected valid=%0b pct=%0d tol=%0d, got %0b/%0d/%0d",
                       $realtime, results_checked, want.is_valid, want.expected_pct,
                       want.tolerance_pct, out_data.is_valid, out_data.expected_pct,
                       out_data.tolerance_pct);
          end
        end
      end
      rx_tick++;
      case (rx_tick[10:9])
        2'd0: rx_rdy = 1'b1;
        2'd1: rx_rdy = 1'($urandom_range(0, 1));
        2'd2: rx_rdy = ($urandom_range(0, 3) == 0);
        default: begin
          if (rx_hold != 0) begin
            rx_hold--;
            rx_rdy = 1'b0;
          end else begin
            rx_rdy = 1'b1;
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(10, 60);
          end
        end
      endcase
      out_ready <= rx_rdy;
    end
  end

  // Watchdog: far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int verr_plan [PHASES];
    int mtol_plan [PHASES];
    int p;
    int k;
    int v;
    int m;
    int leftover;
    // Extremes of both registers, an out-of-range minimum tolerance whose top bit
    // is dropped by the register, three random settings, and back to the defaults.
    verr_plan = '{0, 255, 255, 0, 120, 0, 0, 0, 53};
    mtol_plan = '{0, 100, 0, 127, 200, 0, 0, 0, 5};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed readings under the reset values. Start with the field extremes: an empty
    // cell well below the curve (the window's lower bound is negative there), a voltage
    // far above the curve, and the top and bottom points and their neighbors.
    queue_plain(0, 0);
    queue_plain(8191, 127);
    queue_plain(5119, 100);
    queue_plain(4100, 100);
    queue_plain(4101, 0);
    queue_plain(3300, 0);
    queue_plain(3299, 127);
    // Interior curve points exactly, alternately just outside and just inside the window.
    for (k = 1; k < NPTS - 1; k++) begin
      if (k % 2) queue_near(curve_mv[k], 1, 0);
      else queue_near(curve_mv[k], -1, 1);
    end
    // Segment midpoints, probing both window edges at the boundary.
    queue_near(3990, 1, -1);
    queue_near(3740, -1, 0);
    queue_near(3700, 1, -1);
    queue_near(3630, -1, 1);
    queue_near(3530, 1, 0);
    queue_near(3400, -1, 0);
    queue_near(3800, 0, 0);
    queue_near(3350, 0, 0);
    queue_near(4000, -1, -1);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      if (p >= 5 && p <= 7) begin
        v = $urandom_range(0, 255);
        m = $urandom_range(0, 127);
      end else begin
        v = verr_plan[p];
        m = mtol_plan[p];
      end
      write_register(REG_VOLT_ERROR, v[CFG_DATA_W-1:0]);
      write_register(REG_MIN_TOL, m[CFG_DATA_W-1:0]);
      settings_seen++;
      for (k = 0; k < READINGS_PER_PHASE; k++) queue_random_reading();
      wait_drained();
    end

    // Allow the longest search plus the divider to flush out any stray result.
    repeat (120) @(posedge clk);
    leftover = predicted_results.size();

    $display("Checked %0d of %0d readings across %0d register settings.",
             results_checked, words_sent, settings_seen);
    $display("Capacity inside window: %0d, outside: %0d; stray results: %0d.",
             inside_count, outside_count, unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0 && leftover == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### soc_curve_interp_validate.f
design/scv_pkg.sv
design/soc_curve_interp_validate.sv
dv/tb.sv
